// ===== rtl/bhbt_pkg.sv =====
// Package for the buffer hazard barrier tracker.
// Holds request codes, usage decode and controller state/command types. No dependencies.
package bhbt_pkg;

    typedef enum logic [1:0] {
        REQ_RECORD = 2'd0,
        REQ_EMIT   = 2'd1,
        REQ_CLEAR  = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    localparam logic [5:0] WRITE_BITS = 6'h2A;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_UPDATE,
        ST_WALK,
        ST_EMPTY
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;     // latch the request word
        logic clr_all;     // clear table
        logic search;      // compare key against all valid entries (registered)
        logic update;      // apply the record
        logic walk_start;  // reset walk pointer
        logic walk_step;   // process one entry, advance pointer
        logic emit_empty;  // drive the empty terminating result
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic walk_done;   // pointer past last allocated entry, no barrier held
        logic any_emitted; // some barrier already given this emit
    } stat_t;

    function automatic logic [2:0] stage_of(input logic [2:0] u);
        case (u)
            3'd2, 3'd3: stage_of = 3'd2;
            3'd4, 3'd5: stage_of = 3'd4;
            default:    stage_of = 3'd1;
        endcase
    endfunction

    function automatic logic [5:0] access_of(input logic [2:0] u);
        case (u)
            3'd1:    access_of = 6'h02;
            3'd2:    access_of = 6'h04;
            3'd3:    access_of = 6'h08;
            3'd4:    access_of = 6'h10;
            3'd5:    access_of = 6'h20;
            default: access_of = 6'h01;
        endcase
    endfunction

endpackage

// ===== rtl/buffer_hazard_barrier_tracker_unit.sv =====
// Top level of the buffer read/write hazard tracker.
// Instantiates bhbt_ctrl and bhbt_datapath; depends on bhbt_pkg.
//
// A word is accepted when start is high and busy is low. A record passes
// through accept, a registered key match over the table, then the update. A
// clear completes in its accept cycle. An emit walks allocated entries one
// per cycle: accept, one walk step per entry, then either a flush step for
// the held barrier and a closing state, or a closing state and the empty
// result; the walk pointer sets the length of the walk.
// Results appear on the result ports for one cycle with strobe high and
// cannot be held off; last marks the final result of an emit. The table
// holds TABLE_DEPTH entries in first-use order; overflow is sticky until
// a clear.
module buffer_hazard_barrier_tracker_unit
    import bhbt_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  req_type,
    input  logic [63:0] buffer_handle,
    input  logic [63:0] buffer_offset,
    input  logic [63:0] access_size,
    input  logic [2:0]  usage,
    output logic        strobe,
    output logic        barrier_valid,
    output logic [2:0]  src_stage,
    output logic [5:0]  src_access,
    output logic [2:0]  dst_stage,
    output logic [5:0]  dst_access,
    output logic [63:0] out_handle,
    output logic [63:0] out_offset,
    output logic [63:0] out_size,
    output logic        overflow,
    output logic        last
);

    cmd_t  cmd;
    stat_t stat;

    bhbt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req_type),
        .stat     (stat),
        .cmd      (cmd),
        .busy     (busy)
    );

    bhbt_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .buffer_handle (buffer_handle),
        .buffer_offset (buffer_offset),
        .access_size   (access_size),
        .usage         (usage),
        .strobe        (strobe),
        .barrier_valid (barrier_valid),
        .src_stage     (src_stage),
        .src_access    (src_access),
        .dst_stage     (dst_stage),
        .dst_access    (dst_access),
        .out_handle    (out_handle),
        .out_offset    (out_offset),
        .out_size      (out_size),
        .overflow      (overflow),
        .last          (last)
    );

endmodule

// ===== rtl/bhbt_ctrl.sv =====
// Controller state machine of the hazard tracker.
// Depends on bhbt_pkg.
module bhbt_ctrl
    import bhbt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [1:0] req_type,
    input  stat_t      stat,
    output cmd_t       cmd,
    output logic       busy
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = (state_reg != ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    case (req_type)
                        REQ_RECORD: state_next = ST_SEARCH;
                        REQ_EMIT:
                        begin
                            cmd.walk_start = 1'b1;
                            state_next     = ST_WALK;
                        end
                        REQ_CLEAR: cmd.clr_all = 1'b1;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SEARCH:
            begin
                cmd.search = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = ST_IDLE;
            end
            ST_WALK:
            begin
                if (stat.walk_done)
                begin
                    state_next = stat.any_emitted ? ST_IDLE : ST_EMPTY;
                end
                else
                begin
                    cmd.walk_step = 1'b1;
                end
            end
            ST_EMPTY:
            begin
                cmd.emit_empty = 1'b1;
                state_next     = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// ===== rtl/bhbt_datapath.sv =====
// Datapath of the hazard tracker: entry table, key match, walk and result register.
// Depends on bhbt_pkg.
module bhbt_datapath
    import bhbt_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output stat_t       stat,
    input  logic [63:0] buffer_handle,
    input  logic [63:0] buffer_offset,
    input  logic [63:0] access_size,
    input  logic [2:0]  usage,
    output logic        strobe,
    output logic        barrier_valid,
    output logic [2:0]  src_stage,
    output logic [5:0]  src_access,
    output logic [2:0]  dst_stage,
    output logic [5:0]  dst_access,
    output logic [63:0] out_handle,
    output logic [63:0] out_offset,
    output logic [63:0] out_size,
    output logic        overflow,
    output logic        last
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic [63:0] ent_handle_reg [TABLE_DEPTH];
    logic [63:0] ent_offset_reg [TABLE_DEPTH];
    logic [2:0]  prev_stage_reg [TABLE_DEPTH];
    logic [5:0]  prev_access_reg[TABLE_DEPTH];
    logic [63:0] prev_size_reg  [TABLE_DEPTH];
    logic [2:0]  curr_stage_reg [TABLE_DEPTH];
    logic [5:0]  curr_access_reg[TABLE_DEPTH];
    logic [63:0] curr_size_reg  [TABLE_DEPTH];
    logic        curr_wr_reg    [TABLE_DEPTH];

    logic [CW-1:0] count_reg;
    logic          ovf_reg;
    logic [CW-1:0] ptr_reg;
    logic          emitted_reg;

    logic [63:0] h_reg, o_reg, sz_reg;
    logic [2:0]  u_reg;

    logic          hit_reg;
    logic [IW-1:0] hit_idx_reg;

    // registered key match over valid entries (index < count)
    logic          hit_any;
    logic [IW-1:0] hit_idx;
    always_comb
    begin
        hit_any = 1'b0;
        hit_idx = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--)
        begin
            if (CW'(i) < count_reg && ent_handle_reg[i] == h_reg
                && ent_offset_reg[i] == o_reg)
            begin
                hit_any = 1'b1;
                hit_idx = IW'(i);
            end
        end
    end

    logic          full;
    logic [IW-1:0] upd_idx;
    logic          upd_new;
    assign full    = (count_reg == CW'(TABLE_DEPTH));
    assign upd_new = !hit_reg && !full;
    assign upd_idx = hit_reg ? hit_idx_reg : count_reg[IW-1:0];

    // walk evaluation of the entry at the pointer
    logic [IW-1:0] wi;
    logic          p_has, c_has, p_wr, c_wr, bar;
    logic [63:0]   wsz;
    assign wi    = ptr_reg[IW-1:0];
    assign p_has = (prev_stage_reg[wi] != '0) || (prev_access_reg[wi] != '0);
    assign c_has = (curr_stage_reg[wi] != '0) || (curr_access_reg[wi] != '0);
    assign p_wr  = (prev_access_reg[wi] & WRITE_BITS) != '0;
    assign c_wr  = curr_wr_reg[wi];
    assign wsz   = (prev_size_reg[wi] > curr_size_reg[wi]) ? prev_size_reg[wi]
                                                           : curr_size_reg[wi];
    assign bar   = (p_wr || c_wr) && p_has && c_has && (wsz != '0);

    // last barrier: no later entry will give one; known only when walk ends,
    // so a found barrier is held and released when the next one (or end) is seen
    logic        pend_reg;
    logic [2:0]  ps_reg, ds_reg;
    logic [5:0]  pa_reg, da_reg;
    logic [63:0] ph_reg, po_reg, psz_reg;

    assign stat.walk_done   = (ptr_reg >= count_reg) && !pend_reg;
    assign stat.any_emitted = emitted_reg;

    logic walk_end;
    assign walk_end = (ptr_reg >= count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            ptr_reg     <= '0;
            emitted_reg <= 1'b0;
            hit_reg     <= 1'b0;
            pend_reg    <= 1'b0;
            strobe      <= 1'b0;
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                prev_stage_reg[i]  <= '0;
                prev_access_reg[i] <= '0;
                prev_size_reg[i]   <= '0;
                curr_stage_reg[i]  <= '0;
                curr_access_reg[i] <= '0;
                curr_size_reg[i]   <= '0;
                curr_wr_reg[i]     <= 1'b0;
            end
        end
        else
        begin
            strobe <= cmd.emit_empty || (cmd.walk_step && pend_reg && (walk_end || bar));
            if (cmd.capture)
            begin
                h_reg  <= buffer_handle;
                o_reg  <= buffer_offset;
                sz_reg <= access_size;
                u_reg  <= usage;
            end
            if (cmd.clr_all)
            begin
                count_reg <= '0;
                ovf_reg   <= 1'b0;
            end
            if (cmd.search)
            begin
                hit_reg     <= hit_any;
                hit_idx_reg <= hit_idx;
            end
            if (cmd.update)
            begin
                if (!hit_reg && full)
                begin
                    ovf_reg <= 1'b1;
                end
                else
                begin
                    if (upd_new)
                    begin
                        count_reg               <= count_reg + CW'(1);
                        ent_handle_reg[upd_idx] <= h_reg;
                        ent_offset_reg[upd_idx] <= o_reg;
                        prev_stage_reg[upd_idx] <= '0;
                        prev_access_reg[upd_idx] <= '0;
                        prev_size_reg[upd_idx]  <= '0;
                        curr_stage_reg[upd_idx] <= stage_of(u_reg);
                        curr_access_reg[upd_idx] <= access_of(u_reg);
                        curr_size_reg[upd_idx]  <= sz_reg;
                        curr_wr_reg[upd_idx]    <= (access_of(u_reg) & WRITE_BITS) != '0;
                    end
                    else
                    begin
                        curr_stage_reg[upd_idx]  <= curr_stage_reg[upd_idx]
                                                    | stage_of(u_reg);
                        curr_access_reg[upd_idx] <= curr_access_reg[upd_idx]
                                                    | access_of(u_reg);
                        if ((access_of(u_reg) & WRITE_BITS) != '0)
                        begin
                            curr_wr_reg[upd_idx] <= 1'b1;
                        end
                        if (sz_reg > curr_size_reg[upd_idx])
                        begin
                            curr_size_reg[upd_idx] <= sz_reg;
                        end
                    end
                end
            end
            if (cmd.walk_start)
            begin
                ptr_reg     <= '0;
                emitted_reg <= 1'b0;
                pend_reg    <= 1'b0;
            end
            if (cmd.walk_step)
            begin
                if (!walk_end)
                begin
                    ptr_reg <= ptr_reg + CW'(1);
                    prev_stage_reg[wi]  <= curr_stage_reg[wi];
                    prev_access_reg[wi] <= curr_access_reg[wi];
                    prev_size_reg[wi]   <= curr_size_reg[wi];
                    curr_stage_reg[wi]  <= '0;
                    curr_access_reg[wi] <= '0;
                    curr_size_reg[wi]   <= '0;
                    curr_wr_reg[wi]     <= 1'b0;
                end
                if (pend_reg && (walk_end || bar))
                begin
                    barrier_valid <= 1'b1;
                    src_stage     <= ps_reg;
                    src_access    <= pa_reg;
                    dst_stage     <= ds_reg;
                    dst_access    <= da_reg;
                    out_handle    <= ph_reg;
                    out_offset    <= po_reg;
                    out_size      <= psz_reg;
                    overflow      <= ovf_reg;
                    last          <= walk_end;
                    emitted_reg   <= 1'b1;
                end
                if (walk_end)
                begin
                    pend_reg <= 1'b0;
                end
                else if (bar)
                begin
                    pend_reg <= 1'b1;
                    ps_reg   <= prev_stage_reg[wi];
                    pa_reg   <= prev_access_reg[wi];
                    ds_reg   <= curr_stage_reg[wi];
                    da_reg   <= curr_access_reg[wi];
                    ph_reg   <= ent_handle_reg[wi];
                    po_reg   <= ent_offset_reg[wi];
                    psz_reg  <= wsz;
                end
            end
            if (cmd.emit_empty)
            begin
                barrier_valid <= 1'b0;
                src_stage     <= '0;
                src_access    <= '0;
                dst_stage     <= '0;
                dst_access    <= '0;
                out_handle    <= '0;
                out_offset    <= '0;
                out_size      <= '0;
                overflow      <= ovf_reg;
                last          <= 1'b1;
            end
        end
    end

endmodule

// ===== sim/buffer_hazard_barrier_tracker_unit_test.sv =====
// Self-checking testbench for the buffer read/write hazard tracker.
// Drives record/emit/clear words, predicts barrier results; depends on bhbt_pkg and the RTL.
`timescale 1ns / 1ps

module buffer_hazard_barrier_tracker_unit_test;
    import bhbt_pkg::*;

    localparam int DEPTH = 16;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  req_type = REQ_NONE;
    logic [63:0] buffer_handle = '0;
    logic [63:0] buffer_offset = '0;
    logic [63:0] access_size = '0;
    logic [2:0]  usage = '0;
    logic        strobe;
    logic        barrier_valid;
    logic [2:0]  src_stage;
    logic [5:0]  src_access;
    logic [2:0]  dst_stage;
    logic [5:0]  dst_access;
    logic [63:0] out_handle;
    logic [63:0] out_offset;
    logic [63:0] out_size;
    logic        overflow;
    logic        last;

    // one result word as it leaves the block
    typedef struct packed {
        logic        bvalid;
        logic [2:0]  sstage;
        logic [5:0]  sacc;
        logic [2:0]  dstage;
        logic [5:0]  dacc;
        logic [63:0] handle;
        logic [63:0] offset;
        logic [63:0] size;
        logic        ovf;
        logic        last;
    } barrier_t;

    // one stimulus row; chk marks a typed-in expectation for emits
    typedef struct {
        req_t        req;
        logic [63:0] h;
        logic [63:0] o;
        logic [63:0] sz;
        logic [2:0]  u;
        bit          chk;
        barrier_t    want;
    } row_t;

    barrier_t barrier_q[$];
    int       errors = 0;
    int       received = 0;

    // predictor copy of the hazard table
    logic        t_valid [DEPTH];
    logic [63:0] t_handle[DEPTH];
    logic [63:0] t_offset[DEPTH];
    logic [2:0]  t_pstage[DEPTH];
    logic [5:0]  t_pacc  [DEPTH];
    logic [63:0] t_psize [DEPTH];
    logic [2:0]  t_cstage[DEPTH];
    logic [5:0]  t_cacc  [DEPTH];
    logic [63:0] t_csize [DEPTH];
    logic        t_cwr   [DEPTH];
    int          t_count;
    logic        t_ovf;

    // a few keys reused heavily so random records hit existing entries
    logic [63:0] key_h[8];
    logic [63:0] key_o[8];

    buffer_hazard_barrier_tracker_unit #(.TABLE_DEPTH(DEPTH)) DUT (.*);

    always #4 clk = ~clk;

    // generous limit: far above the time for 120 words, each with a full walk, plus gaps
    initial
    begin
        #20ms;
        $display("** buffer_hazard_barrier_tracker_unit: FAILED **");
        $finish;
    end

    function automatic void table_clear();
        for (int i = 0; i < DEPTH; i++)
        begin
            t_valid[i] = 0; t_handle[i] = '0; t_offset[i] = '0;
            t_pstage[i] = '0; t_pacc[i] = '0; t_psize[i] = '0;
            t_cstage[i] = '0; t_cacc[i] = '0; t_csize[i] = '0; t_cwr[i] = 0;
        end
        t_count = 0;
        t_ovf = 0;
    endfunction

    function automatic logic [2:0] stage_mask(logic [2:0] u);
        case (u)
            3'd2, 3'd3: return 3'b010;
            3'd4, 3'd5: return 3'b100;
            default:    return 3'b001;
        endcase
    endfunction

    function automatic logic [5:0] access_mask(logic [2:0] u);
        logic [5:0] m;
        m = '0;
        if (u <= 3'd5)
            m[u] = 1'b1;
        else
            m[0] = 1'b1;
        return m;
    endfunction

    function automatic void record_usage(logic [63:0] h, logic [63:0] o,
                                         logic [63:0] sz, logic [2:0] u);
        int hit;
        logic [5:0] acc;
        hit = -1;
        for (int i = 0; i < DEPTH; i++)
            if (hit < 0 && t_valid[i] && t_handle[i] == h && t_offset[i] == o)
                hit = i;
        if (hit < 0)
        begin
            if (t_count >= DEPTH)
            begin
                t_ovf = 1;
                return;
            end
            hit = t_count++;
            t_valid[hit] = 1; t_handle[hit] = h; t_offset[hit] = o;
            t_pstage[hit] = '0; t_pacc[hit] = '0; t_psize[hit] = '0;
            t_cstage[hit] = '0; t_cacc[hit] = '0; t_csize[hit] = '0; t_cwr[hit] = 0;
        end
        acc = access_mask(u);
        t_cstage[hit] |= stage_mask(u);
        t_cacc[hit]   |= acc;
        if ((acc & WRITE_BITS) != 0)
            t_cwr[hit] = 1;
        if (sz > t_csize[hit])
            t_csize[hit] = sz;
    endfunction

    // append one expected word
    function automatic void expect_word(barrier_t b);
        barrier_q = {barrier_q, b};
    endfunction

    // walk the table, queue barriers, promote current to previous
    function automatic void emit_barriers();
        int n;
        logic [63:0] sz;
        barrier_t b;
        n = 0;
        for (int i = 0; i < t_count; i++)
        begin
            sz = (t_psize[i] > t_csize[i]) ? t_psize[i] : t_csize[i];
            if ((((t_pacc[i] & WRITE_BITS) != 0) || t_cwr[i])
                && (t_pstage[i] != 0 || t_pacc[i] != 0)
                && (t_cstage[i] != 0 || t_cacc[i] != 0) && sz != 0)
            begin
                b = '{1'b1, t_pstage[i], t_pacc[i], t_cstage[i], t_cacc[i],
                      t_handle[i], t_offset[i], sz, t_ovf, 1'b0};
                expect_word(b);
                n++;
            end
            t_pstage[i] = t_cstage[i]; t_pacc[i] = t_cacc[i]; t_psize[i] = t_csize[i];
            t_cstage[i] = '0; t_cacc[i] = '0; t_csize[i] = '0; t_cwr[i] = 0;
        end
        if (n == 0)
        begin
            b = '0;
            b.ovf = t_ovf;
            b.last = 1'b1;
            expect_word(b);
        end
        else
            barrier_q[$].last = 1'b1;
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch on result %0d: %s got %0h want %0h", received, what, got, want);
        errors++;
    endtask

    // result checker: every strobe is compared with the oldest expectation
    always @(posedge clk)
    begin
        barrier_t want;
        if (rst_n && strobe)
        begin
            if (barrier_q.size() == 0)
            begin
                $display("unexpected result word at %0t", $realtime);
                errors++;
            end
            else
            begin
                want = barrier_q.pop_front();
                if (barrier_valid !== want.bvalid) report("barrier_valid", barrier_valid, want.bvalid);
                if (src_stage !== want.sstage)     report("src_stage", src_stage, want.sstage);
                if (src_access !== want.sacc)      report("src_access", src_access, want.sacc);
                if (dst_stage !== want.dstage)     report("dst_stage", dst_stage, want.dstage);
                if (dst_access !== want.dacc)      report("dst_access", dst_access, want.dacc);
                if (out_handle !== want.handle)    report("out_handle", out_handle, want.handle);
                if (out_offset !== want.offset)    report("out_offset", out_offset, want.offset);
                if (out_size !== want.size)        report("out_size", out_size, want.size);
                if (overflow !== want.ovf)         report("overflow", overflow, want.ovf);
                if (last !== want.last)            report("last", last, want.last);
            end
            received++;
        end
    end

    // burst/gap pacing state for the sender
    int burst_left = 0;

    // drive one word at the falling edge and hold until accepted;
    // busy is sampled at the falling edge, before the accepting edge
    task automatic send(req_t rq, logic [63:0] h, logic [63:0] o,
                        logic [63:0] sz, logic [2:0] u);
        logic idle_seen;
        if (burst_left == 0)
        begin
            repeat ($urandom_range(0, 6)) @(negedge clk);
            burst_left = $urandom_range(1, 10);
        end
        burst_left--;
        req_type = rq; buffer_handle = h; buffer_offset = o;
        access_size = sz; usage = u; start = 1'b1;
        forever
        begin
            idle_seen = !busy;
            @(posedge clk);
            if (idle_seen)
                break;
            @(negedge clk);
        end
        case (rq)
            REQ_RECORD: record_usage(h, o, sz, u);
            REQ_EMIT:   emit_barriers();
            REQ_CLEAR:  table_clear();
            default:    ;
        endcase
        @(negedge clk);
        start = 1'b0;
    endtask

    task automatic drain();
        while (barrier_q.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic row_t rec(logic [63:0] h, logic [63:0] o, logic [63:0] sz,
                                 logic [2:0] u);
        return '{REQ_RECORD, h, o, sz, u, 0, '0};
    endfunction

    function automatic row_t op(req_t r);
        return '{r, '0, '0, '0, 3'd0, 0, '0};
    endfunction

    function automatic row_t emit_known(barrier_t w);
        return '{REQ_EMIT, '0, '0, '0, 3'd0, 1, w};
    endfunction

    localparam logic [63:0] ALL1 = 64'hFFFF_FFFF_FFFF_FFFF;

    initial
    begin
        row_t     plan[$];
        barrier_t empty_word;
        barrier_t head;
        int       k;
        int       pick;

        table_clear();
        for (int i = 0; i < 8; i++)
        begin
            key_h[i] = (i < 2) ? (i == 0 ? 64'd0 : ALL1) : rand64();
            key_o[i] = (i < 2) ? (i == 0 ? ALL1 : 64'd0) : rand64();
        end
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table
        empty_word = '0;
        empty_word.last = 1'b1;
        plan = {plan, emit_known(empty_word)};                  // empty table after reset
        plan = {plan, op(REQ_NONE)};                            // unknown request ignored
        plan = {plan, rec(64'd0, ALL1, ALL1, 3'd1)};            // compute write, max size
        plan = {plan, rec(64'd0, ALL1, 64'd5, 3'd6)};           // usage 6 reads as compute
        plan = {plan, op(REQ_EMIT)};                            // no previous yet
        plan = {plan, rec(64'd0, ALL1, 64'd0, 3'd4)};           // host read after write
        plan = {plan, rec(ALL1, 64'd0, 64'd0, 3'd5)};           // zero size write
        head = '{1'b1, 3'b001, 6'h03, 3'b100, 6'h10, 64'd0, ALL1, ALL1, 1'b0, 1'b1};
        plan = {plan, emit_known(head)};
        plan = {plan, rec(ALL1, 64'd0, 64'd0, 3'd2)};           // zero size on both sides
        plan = {plan, rec(ALL1, ALL1, 64'd9, 3'd3)};
        plan = {plan, rec(ALL1, ALL1, 64'd1, 3'd7)};
        plan = {plan, op(REQ_EMIT)};
        plan = {plan, op(REQ_EMIT)};                            // masks promoted to zero
        plan = {plan, rec(ALL1, ALL1, 64'd3, 3'd0)};            // reuse of an idle entry
        plan = {plan, op(REQ_EMIT)};
        plan = {plan, op(REQ_CLEAR)};
        plan = {plan, emit_known(empty_word)};
        foreach (plan[i])
        begin
            send(plan[i].req, plan[i].h, plan[i].o, plan[i].sz, plan[i].u);
            if (plan[i].chk && barrier_q.size() != 0 && barrier_q[$] !== plan[i].want)
            begin
                $display("typed-in expectation differs from predictor at row %0d", i);
                errors++;
            end
        end

        // overflow: fill the table with fresh keys, then one more
        for (int i = 0; i <= DEPTH; i++)
            send(REQ_RECORD, rand64(), rand64(), rand64(), 3'($urandom_range(0, 7)));
        send(REQ_EMIT, '0, '0, '0, 3'd0);
        send(REQ_RECORD, ALL1, ALL1, 64'd1, 3'd1);
        send(REQ_EMIT, '0, '0, '0, 3'd0);
        // sender waits until every expected word has come
        drain();
        send(REQ_CLEAR, '0, '0, '0, 3'd0);

        // random part: mostly records on a small key set, emits between them
        for (int n = 0; n < 80; n++)
        begin
            pick = $urandom_range(0, 99);
            k = $urandom_range(0, 7);
            if (pick < 65)
                send(REQ_RECORD,
                     ($urandom_range(0, 9) == 0) ? rand64() : key_h[k],
                     ($urandom_range(0, 9) == 0) ? rand64() : key_o[k],
                     ($urandom_range(0, 3) == 0) ? rand64() : 64'($urandom_range(0, 4)),
                     3'($urandom_range(0, 7)));
            else if (pick < 92)
                send(REQ_EMIT, rand64(), rand64(), rand64(), 3'($urandom_range(0, 7)));
            else if (pick < 96)
                send(REQ_CLEAR, rand64(), rand64(), rand64(), 3'($urandom_range(0, 7)));
            else
                send(REQ_NONE, rand64(), rand64(), rand64(), 3'($urandom_range(0, 7)));
            if (n == 40)
                drain();
        end
        send(REQ_EMIT, '0, '0, '0, 3'd0);

        drain();
        repeat (DEPTH + 10) @(posedge clk);
        if (errors == 0)
            $display("** buffer_hazard_barrier_tracker_unit: PASSED **");
        else
            $display("** buffer_hazard_barrier_tracker_unit: FAILED **");
        $finish;
    end

    // expectations left over are caught by the timeout; stray ones by the checker
endmodule
